// File: sv/tprc_pkg.sv
// ---------------------------------------------------------------------------
// tprc_pkg: shared types, codes and helpers for the tank pump run controller
// Field widths, register indexes, message codes and the small arithmetic
// helpers used by the step logic and the controller top level.
// ---------------------------------------------------------------------------
package tprc_pkg;

  // Field widths
  localparam int MINUTES_W  = 8;
  localparam int CONFIRM_W  = 4;
  localparam int BURST_W    = 5;
  localparam int PERIOD_W   = 8;
  localparam int GROUP_W    = 20;
  localparam int SECONDS_W  = 15;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int MODE_W     = 3;
  localparam int LEVEL_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Defaults
  localparam int DEF_MAX_RUN_MINUTES = 180;
  localparam logic [MINUTES_W-1:0] RST_RUN_MINUTES   = 8'd30;
  localparam logic [CONFIRM_W-1:0] RST_CONFIRM_COUNT = 4'd3;
  localparam logic [CONFIRM_W-1:0] RST_STOP_CONFIRM  = 4'd5;
  localparam logic [BURST_W-1:0]   RST_BURST_LENGTH  = 5'd10;
  localparam logic [PERIOD_W-1:0]  RST_RESEND_PERIOD = 8'd60;
  localparam logic [GROUP_W-1:0]   RST_GROUP_ID      = 20'd103302;
  localparam logic [MINUTES_W-1:0] FALLBACK_MINUTES  = 8'd30;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RUN_MINUTES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_CONFIRM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESEND_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_ID      = 3'd5;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  // Report codes
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FAULT = 2'd2;

  // Sensor levels
  localparam logic [LEVEL_W-1:0] LVL_FULL    = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_EMPTY   = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_UNKNOWN = 2'd2;

  // Display modes
  localparam logic [MODE_W-1:0] MODE_NONE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BLANK   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FULL    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EMPTY   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MINUTES = 3'd4;

  typedef struct packed {
    logic [MINUTES_W-1:0] run_minutes;
    logic [CONFIRM_W-1:0] confirm_count;
    logic [CONFIRM_W-1:0] stop_confirm;
    logic [BURST_W-1:0]   burst_length;
    logic [PERIOD_W-1:0]  resend_period;
    logic [GROUP_W-1:0]   group_id;
  } cfg_t;

  typedef struct packed {
    logic                 running;
    logic [SECONDS_W-1:0] seconds_left;
    logic [CONFIRM_W-1:0] full_run;
    logic [CONFIRM_W-1:0] empty_run;
    logic [CONFIRM_W-1:0] fault_run;
    logic [CONFIRM_W-1:0] stop_run;
    logic [LEVEL_W-1:0]   level_state;
    logic                 burst_active;
    logic [BURST_W-1:0]   burst_sent;
    logic [PERIOD_W-1:0]  resend_timer;
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [GROUP_W-1:0]  msg_group;
    logic [STATUS_W-1:0] msg_status;
  } item_t;

  typedef struct packed {
    logic                 motor_on;
    logic                 send_frame;
    logic [MODE_W-1:0]    display_mode;
    logic [MINUTES_W-1:0] display_minutes;
    logic [LEVEL_W-1:0]   sensor_state;
  } result_t;

  // Run time in seconds; out-of-range minutes fall back to the default
  function automatic logic [SECONDS_W-1:0] run_seconds(input logic [MINUTES_W-1:0] m,
                                                       input logic [MINUTES_W-1:0] max_m);
    logic [MINUTES_W-1:0] mm;
    logic [SECONDS_W-1:0] w;
    mm = ((m == '0) || (m > max_m)) ? FALLBACK_MINUTES : m;
    w  = {{(SECONDS_W-MINUTES_W){1'b0}}, mm};
    return (w << 6) - (w << 2);
  endfunction

  // Saturating count up to 15
  function automatic logic [CONFIRM_W-1:0] sat_inc(input logic [CONFIRM_W-1:0] v);
    return (v == '1) ? v : v + 4'd1;
  endfunction

  // Minutes shown: seconds / 60 + 1, via (s >> 2) / 15 by reciprocal multiply
  function automatic logic [MINUTES_W-1:0] show_minutes(input logic [SECONDS_W-1:0] s);
    logic [25:0] t;
    logic [25:0] p;
    t = {13'd0, s[SECONDS_W-1:2]};
    p = (t + 26'd1) * 26'd4369;
    return p[23:16] + 8'd1;
  endfunction

endpackage

// File: sv/tprc_cfg_regs.sv
// ---------------------------------------------------------------------------
// tprc_cfg_regs: configuration register file
// Decodes the register index of each write request and holds the six
// configuration fields; writes beyond the list are taken and dropped.
// ---------------------------------------------------------------------------
module tprc_cfg_regs import tprc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  // Update the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_minutes   <= RST_RUN_MINUTES;
      cfg.confirm_count <= RST_CONFIRM_COUNT;
      cfg.stop_confirm  <= RST_STOP_CONFIRM;
      cfg.burst_length  <= RST_BURST_LENGTH;
      cfg.resend_period <= RST_RESEND_PERIOD;
      cfg.group_id      <= RST_GROUP_ID;
    end else if (wr_en) begin
      case (wr_index)
        REG_RUN_MINUTES:   cfg.run_minutes   <= wr_data[MINUTES_W-1:0];
        REG_CONFIRM_COUNT: cfg.confirm_count <= wr_data[CONFIRM_W-1:0];
        REG_STOP_CONFIRM:  cfg.stop_confirm  <= wr_data[CONFIRM_W-1:0];
        REG_BURST_LENGTH:  cfg.burst_length  <= wr_data[BURST_W-1:0];
        REG_RESEND_PERIOD: cfg.resend_period <= wr_data[PERIOD_W-1:0];
        REG_GROUP_ID:      cfg.group_id      <= wr_data[GROUP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/tprc_step.sv
// ---------------------------------------------------------------------------
// tprc_step: single-item update logic
// Given the current controller state, configuration and one request, forms
// the next state and the result: report debounce, button toggle, tick
// countdown, stop confirmation and status burst scheduling.
// ---------------------------------------------------------------------------
module tprc_step import tprc_pkg::*; #(
  parameter int MAX_RUN_MINUTES = DEF_MAX_RUN_MINUTES
) (
  input  cfg_t    cfg,
  input  state_t  cur,
  input  item_t   item,
  output state_t  nxt,
  output result_t res
);

  localparam logic [MINUTES_W-1:0] MaxM = MINUTES_W'(MAX_RUN_MINUTES);

  logic [SECONDS_W-1:0] reload;
  logic                 send;
  logic [MODE_W-1:0]    mode;
  logic [MINUTES_W-1:0] minutes;

  assign reload = run_seconds(cfg.run_minutes, MaxM);

  // Apply one request in order, as a sequence of updates on a state copy
  always_comb begin
    nxt     = cur;
    send    = 1'b0;
    mode    = MODE_NONE;
    minutes = '0;
    case (item.kind)
      KIND_REPORT: begin
        if (item.msg_group == cfg.group_id) begin
          // full reports: stop a running motor once confirmed
          if (item.msg_status == ST_FULL) begin
            mode = MODE_FULL;
            nxt.full_run = sat_inc(cur.full_run);
            if (nxt.full_run >= cfg.confirm_count && cur.running) begin
              nxt.running      = 1'b0;
              nxt.seconds_left = reload;
              nxt.level_state  = LVL_FULL;
              nxt.burst_active = 1'b1;
              nxt.burst_sent   = '0;
              nxt.resend_timer = '0;
              nxt.full_run     = '0;
            end
          end else begin
            nxt.full_run = '0;
          end
          // empty reports: start a stopped motor once confirmed
          if (item.msg_status == ST_EMPTY) begin
            mode = MODE_EMPTY;
            nxt.empty_run = sat_inc(cur.empty_run);
            if (nxt.empty_run >= cfg.confirm_count && !cur.running) begin
              nxt.running      = 1'b1;
              nxt.seconds_left = reload;
              nxt.level_state  = LVL_EMPTY;
              nxt.burst_active = 1'b1;
              nxt.burst_sent   = '0;
              nxt.resend_timer = '0;
              nxt.empty_run    = '0;
            end
          end else begin
            nxt.empty_run = '0;
          end
          // fault reports: mark level unknown once confirmed
          if (item.msg_status == ST_FAULT) begin
            nxt.fault_run = sat_inc(cur.fault_run);
            if (nxt.fault_run >= cfg.confirm_count) begin
              nxt.level_state = LVL_UNKNOWN;
              nxt.fault_run   = '0;
            end
          end else begin
            nxt.fault_run = '0;
          end
        end
      end
      KIND_BUTTON: begin
        // toggle the motor; only a start reloads the countdown
        if (!cur.running) begin
          nxt.running      = 1'b1;
          nxt.seconds_left = reload;
        end else begin
          nxt.running = 1'b0;
        end
        nxt.burst_active = 1'b1;
        nxt.burst_sent   = '0;
        nxt.resend_timer = '0;
      end
      KIND_TICK: begin
        // countdown and stop confirmation while running
        if (cur.running) begin
          if (cur.seconds_left != '0) begin
            nxt.seconds_left = cur.seconds_left - 15'd1;
          end
          mode    = MODE_MINUTES;
          minutes = show_minutes(nxt.seconds_left);
          if (nxt.seconds_left == '0 || cur.level_state == LVL_FULL) begin
            nxt.stop_run = sat_inc(cur.stop_run);
            if (nxt.stop_run >= cfg.stop_confirm) begin
              nxt.running      = 1'b0;
              nxt.seconds_left = reload;
              mode             = MODE_BLANK;
              minutes          = '0;
              nxt.stop_run     = '0;
              nxt.burst_active = 1'b1;
              nxt.burst_sent   = '0;
              nxt.resend_timer = '0;
            end
          end else begin
            nxt.stop_run = '0;
          end
        end
        // advance the resend timer, saturating
        if (nxt.resend_timer != '1) begin
          nxt.resend_timer = nxt.resend_timer + 8'd1;
        end
        // emit one frame of an active burst
        if (nxt.burst_active) begin
          send = 1'b1;
          if (nxt.burst_sent != '1) begin
            nxt.burst_sent = nxt.burst_sent + 5'd1;
          end
          if (nxt.burst_sent >= cfg.burst_length) begin
            nxt.burst_active = 1'b0;
          end
        end
        // periodic burst restart
        if (!nxt.burst_active && nxt.resend_timer >= cfg.resend_period) begin
          nxt.burst_active = 1'b1;
          nxt.burst_sent   = '0;
          nxt.resend_timer = '0;
        end
      end
      default: ;
    endcase
  end

  // Pack the result
  always_comb begin
    res.motor_on        = nxt.running;
    res.send_frame      = send;
    res.display_mode    = mode;
    res.display_minutes = minutes;
    res.sensor_state    = nxt.level_state;
  end

endmodule

// File: sv/tank_pump_run_controller.sv
// Path: an accepted request is held in the input register, passes the step
// logic on advance and lands in the result register, which raises out_valid.
// Throughput: one request per cycle while the output is not stalled, set by
// the combinational step logic between the input and result registers.
// Reset: rst (synchronous) restores state, config and valid flags to defaults,
// motor off, level unknown, countdown at the run time of default run_minutes.
// ---------------------------------------------------------------------------
// tank_pump_run_controller: pump motor controller
// Input register, single-pass update of the controller state, and a result
// register that can hold a finished result while the next request waits.
// ---------------------------------------------------------------------------
module tank_pump_run_controller import tprc_pkg::*; #(
  parameter int MAX_RUN_MINUTES = DEF_MAX_RUN_MINUTES
) (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KIND_W-1:0]     kind,
  input  logic [GROUP_W-1:0]    msg_group,
  input  logic [STATUS_W-1:0]   msg_status,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  motor_on,
  output logic                  send_frame,
  output logic [MODE_W-1:0]     display_mode,
  output logic [MINUTES_W-1:0]  display_minutes,
  output logic [LEVEL_W-1:0]    sensor_state,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [MINUTES_W-1:0] MaxM = MINUTES_W'(MAX_RUN_MINUTES);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  item_t   in_item;
  logic    in_full;
  result_t step_res;
  result_t res;
  logic    advance;
  logic    in_take;

  // Configuration registers
  assign cfg_ready = 1'b1;

  tprc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Handshake control
  assign advance  = in_full & (~out_valid | ~out_stall);
  assign in_stall = in_full & ~advance;
  assign in_take  = in_valid & ~in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
    if (in_take) begin
      in_item.kind       <= kind;
      in_item.msg_group  <= msg_group;
      in_item.msg_status <= msg_status;
    end
  end

  // Step logic
  tprc_step #(
    .MAX_RUN_MINUTES (MAX_RUN_MINUTES)
  ) u_step (
    .cfg  (cfg),
    .cur  (state),
    .item (in_item),
    .nxt  (state_next),
    .res  (step_res)
  );

  // Controller state: commit on advance
  always_ff @(posedge clk) begin
    if (rst) begin
      state.running      <= 1'b0;
      state.seconds_left <= run_seconds(RST_RUN_MINUTES, MaxM);
      state.full_run     <= '0;
      state.empty_run    <= '0;
      state.fault_run    <= '0;
      state.stop_run     <= '0;
      state.level_state  <= LVL_UNKNOWN;
      state.burst_active <= 1'b0;
      state.burst_sent   <= '0;
      state.resend_timer <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      res <= step_res;
    end
  end

  assign motor_on        = res.motor_on;
  assign send_frame      = res.send_frame;
  assign display_mode    = res.display_mode;
  assign display_minutes = res.display_minutes;
  assign sensor_state    = res.sensor_state;

  // Checks
  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    in_take |=> in_full)
    else $error("accepted request not held in input register");

  a_motor_matches_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> (res.motor_on == state.running))
    else $error("result motor_on differs from committed state");

  a_minutes_only_in_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && display_mode != MODE_MINUTES) |-> (display_minutes == '0))
    else $error("minutes shown outside minutes mode");

  a_blank_means_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && display_mode == MODE_BLANK) |-> !motor_on)
    else $error("blank display while motor runs");

endmodule
